// ===== sv/smos_pkg.sv =====
// Shared types, constants and helpers for the sparse one-hot move scorer.
// Used by the head, the neuron cells and the top level.
package smos_pkg;

    localparam int HIDDEN_COUNT = 64;
    localparam int INPUT_COUNT  = 20;
    localparam int WEIGHT_WIDTH = 16;

    localparam int NEURON_W  = $clog2(HIDDEN_COUNT);
    localparam int ROW_W     = $clog2(INPUT_COUNT + 2);
    localparam int HSUM_W    = WEIGHT_WIDTH + 3;
    localparam int PROD_W    = HSUM_W + WEIGHT_WIDTH;
    localparam int ACC_W     = PROD_W + NEURON_W + 2;
    localparam int SCORE_W   = 32;
    localparam int INDEX_W   = 11;
    localparam int VALUE_W   = 16;
    localparam int IN_DATA_W = 112;
    localparam int FRAC_W    = 12;

    localparam int BIAS_ADDR = (INPUT_COUNT + 1) * HIDDEN_COUNT;

    // Row codes of a load word: hidden rows are 0..INPUT_COUNT-1
    localparam logic [ROW_W-1:0] ROW_OUT  = ROW_W'(INPUT_COUNT);
    localparam logic [ROW_W-1:0] ROW_NONE = ROW_W'(INPUT_COUNT + 1);

    // First row of each one-hot group
    localparam logic [ROW_W-1:0] ROW_SEE    = ROW_W'(5);
    localparam logic [ROW_W-1:0] ROW_MARGIN = ROW_W'(6);
    localparam logic [ROW_W-1:0] ROW_MNUM   = ROW_W'(10);
    localparam logic [ROW_W-1:0] ROW_PIECE  = ROW_W'(13);

    localparam logic [2:0] PIECE_NONE_LO = 3'd0;
    localparam logic [2:0] PIECE_NONE_HI = 3'd7;

    typedef struct packed {
        logic                      valid;
        logic                      load;
        logic [ROW_W-1:0]          row;
        logic [NEURON_W-1:0]       neuron;
        logic signed [WEIGHT_WIDTH-1:0] value;
        logic [2:0]                hist_sel;
        logic                      see_en;
        logic [1:0]                margin_sel;
        logic [1:0]                mnum_sel;
        logic [2:0]                piece;
        logic signed [ACC_W-1:0]   acc;
    } item_t;

    // Keep a 16-bit load word to WEIGHT_WIDTH bits, sign-extended
    function automatic logic signed [WEIGHT_WIDTH-1:0] to_weight(
        input logic signed [VALUE_W-1:0] v
    );
        logic signed [63:0] wide;
        logic [WEIGHT_WIDTH-1:0] low;
        begin
            wide = 64'(v);
            low  = wide[WEIGHT_WIDTH-1:0];
            return $signed(low);
        end
    endfunction

endpackage

// ===== sv/smos_head.sv =====
// Input head of the scorer: decodes buckets and load addresses, holds the bias.
// Depends on smos_pkg.
module smos_head import smos_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 take,
    input  logic                 mode,
    input  logic [INDEX_W-1:0]   weight_index,
    input  logic signed [VALUE_W-1:0] weight_value,
    input  logic signed [31:0]   history,
    input  logic signed [15:0]   see_value,
    input  logic signed [16:0]   eval_margin,
    input  logic [7:0]           move_order,
    input  logic [7:0]           moving_piece,
    output item_t                item
);

    logic                      valid_reg;
    item_t                     body_reg;
    item_t                     body_next;
    logic signed [WEIGHT_WIDTH-1:0] bias_reg;

    // Decode the word into chain form
    always_comb
    begin
        body_next            = '0;
        body_next.valid      = 1'b1;
        body_next.load       = mode;
        body_next.row        = ROW_NONE;
        body_next.value      = to_weight(weight_value);
        for (int r = 0; r <= INPUT_COUNT; r++)
        begin
            if (int'(weight_index) >= r * HIDDEN_COUNT &&
                int'(weight_index) < (r + 1) * HIDDEN_COUNT)
            begin
                body_next.row    = ROW_W'(r);
                body_next.neuron = NEURON_W'(int'(weight_index) - r * HIDDEN_COUNT);
            end
        end
        if (history < -32'sd100)
            body_next.hist_sel = 3'd0;
        else if (history < 32'sd0)
            body_next.hist_sel = 3'd1;
        else if (history == 32'sd0)
            body_next.hist_sel = 3'd2;
        else if (history < 32'sd100)
            body_next.hist_sel = 3'd3;
        else
            body_next.hist_sel = 3'd4;
        body_next.see_en = !see_value[15];
        if (eval_margin >= 17'sd0)
            body_next.margin_sel = 2'd0;
        else if (eval_margin >= -17'sd100)
            body_next.margin_sel = 2'd1;
        else if (eval_margin >= -17'sd200)
            body_next.margin_sel = 2'd2;
        else
            body_next.margin_sel = 2'd3;
        if (move_order < 8'd5)
            body_next.mnum_sel = 2'd0;
        else if (move_order < 8'd12)
            body_next.mnum_sel = 2'd1;
        else if (move_order < 8'd29)
            body_next.mnum_sel = 2'd2;
        else
            body_next.mnum_sel = 2'd3;
        body_next.piece = moving_piece[2:0];
        body_next.acc   = ACC_W'(bias_reg) <<< FRAC_W;
    end

    // Track the valid flag of the head stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= take;
    end

    // Capture the payload and load the bias
    always_ff @(posedge clk)
    begin
        if (advance && take)
        begin
            body_reg <= body_next;
            if (mode && int'(weight_index) == BIAS_ADDR)
                bias_reg <= to_weight(weight_value);
        end
    end

    always_comb
    begin
        item       = body_reg;
        item.valid = valid_reg;
    end

endmodule

// ===== sv/smos_cell.sv =====
// One hidden neuron of the scorer chain: its weight column, ReLU and product.
// Depends on smos_pkg.
module smos_cell import smos_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [NEURON_W-1:0] cell_id,
    input  item_t               item_in,
    output item_t               item_out
);

    logic signed [WEIGHT_WIDTH-1:0] hw_reg [INPUT_COUNT];
    logic signed [WEIGHT_WIDTH-1:0] ow_reg;

    logic                      s1_valid_reg;
    item_t                     s1_item_reg;
    logic signed [HSUM_W-1:0]  s1_hidden_reg;
    logic                      s2_valid_reg;
    item_t                     s2_item_reg;

    logic [ROW_W-1:0]          r_hist;
    logic [ROW_W-1:0]          r_margin;
    logic [ROW_W-1:0]          r_mnum;
    logic [ROW_W-1:0]          r_piece;
    logic                      piece_en;
    logic signed [HSUM_W-1:0]  hidden_next;
    logic signed [HSUM_W-1:0]  hidden_pos;
    logic signed [PROD_W-1:0]  prod;
    item_t                     s2_next;

    // Sum the weights of the active rows
    always_comb
    begin
        r_hist   = ROW_W'(item_in.hist_sel);
        r_margin = ROW_MARGIN + ROW_W'(item_in.margin_sel);
        r_mnum   = ROW_MNUM + ROW_W'(item_in.mnum_sel);
        r_piece  = ROW_PIECE + ROW_W'(item_in.piece);
        piece_en = item_in.piece != PIECE_NONE_LO && item_in.piece != PIECE_NONE_HI;
        hidden_next = HSUM_W'(hw_reg[r_hist]) + HSUM_W'(hw_reg[r_margin])
                    + HSUM_W'(hw_reg[r_mnum]);
        if (item_in.see_en)
            hidden_next = hidden_next + HSUM_W'(hw_reg[ROW_SEE]);
        if (piece_en)
            hidden_next = hidden_next + HSUM_W'(hw_reg[r_piece]);
    end

    // Apply ReLU, weigh and accumulate
    always_comb
    begin
        hidden_pos = (s1_hidden_reg > 0) ? s1_hidden_reg : '0;
        prod       = PROD_W'(hidden_pos) * PROD_W'(ow_reg);
        s2_next    = s1_item_reg;
        if (!s1_item_reg.load)
            s2_next.acc = s1_item_reg.acc + ACC_W'(prod);
    end

    // Advance the stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payload and write weights addressed to this neuron
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg   <= item_in;
            s1_hidden_reg <= hidden_next;
            s2_item_reg   <= s2_next;
            if (item_in.valid && item_in.load && item_in.neuron == cell_id)
            begin
                if (item_in.row < ROW_OUT)
                    hw_reg[item_in.row] <= item_in.value;
                else if (item_in.row == ROW_OUT)
                    ow_reg <= item_in.value;
            end
        end
    end

    always_comb
    begin
        item_out       = s2_item_reg;
        item_out.valid = s2_valid_reg;
    end

endmodule

// ===== sv/sparse_onehot_mlp_score.sv =====
// Move scorer: two-layer ReLU network over one-hot buckets, one neuron per cell.
// Pipeline: head register, two stages per cell, output register.
// Throughput: one word per cycle unless the output stalls; loads travel the chain in order with evaluates.
// Reset clears all valid flags; weights and bias are undefined until loaded.
// Depends on smos_pkg, smos_head and smos_cell.
module sparse_onehot_mlp_score import smos_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [10:0] weight_index, [26:11] weight_value, [58:27] history,
    // [74:59] see_value, [91:75] eval_margin, [99:92] move_order,
    // [107:100] moving_piece, rest zero
    input  logic [IN_DATA_W-1:0] s_tdata,
    // [0] mode
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] score
    output logic [SCORE_W-1:0]   m_tdata
);

    item_t chain [HIDDEN_COUNT+1];
    logic  advance;
    logic  tail_eval;
    logic  out_valid_reg;
    logic  [SCORE_W-1:0] score_reg;
    logic  [SCORE_W-1:0] score_next;

    // Stall only when the tail has a score and the output slot is blocked
    assign tail_eval = chain[HIDDEN_COUNT].valid && !chain[HIDDEN_COUNT].load;
    assign advance   = !(out_valid_reg && !m_tready && tail_eval);
    assign s_tready  = advance;

    smos_head u_head (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .take         (s_tvalid),
        .mode         (s_tuser[0]),
        .weight_index (s_tdata[10:0]),
        .weight_value (s_tdata[26:11]),
        .history      (s_tdata[58:27]),
        .see_value    (s_tdata[74:59]),
        .eval_margin  (s_tdata[91:75]),
        .move_order   (s_tdata[99:92]),
        .moving_piece (s_tdata[107:100]),
        .item         (chain[0])
    );

    for (genvar n = 0; n < HIDDEN_COUNT; n++)
    begin : g_cell
        smos_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_id  (NEURON_W'(n)),
            .item_in  (chain[n]),
            .item_out (chain[n+1])
        );
    end

    // Saturate the Q8.24 sum to 32 bits
    always_comb
    begin
        if (chain[HIDDEN_COUNT].acc > ACC_W'(64'sd2147483647))
            score_next = {1'b0, {(SCORE_W-1){1'b1}}};
        else if (chain[HIDDEN_COUNT].acc < ACC_W'(-64'sd2147483648))
            score_next = {1'b1, {(SCORE_W-1){1'b0}}};
        else
            score_next = chain[HIDDEN_COUNT].acc[SCORE_W-1:0];
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance && tail_eval)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_eval)
            score_reg <= score_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = score_reg;

endmodule

// ===== tb/sparse_onehot_mlp_score_checker.sv =====
// Checker for the move scorer: tracks the weight store from load words, predicts the
// score of every evaluate word and compares it with each result word in order.
// Depends on smos_pkg for widths and addresses.
module sparse_onehot_mlp_score_checker import smos_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [SCORE_W-1:0]   m_tdata,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIDDEN_WORDS = INPUT_COUNT * HIDDEN_COUNT;

    logic signed [WEIGHT_WIDTH-1:0] hid_w [HIDDEN_WORDS];
    logic signed [WEIGHT_WIDTH-1:0] out_w [HIDDEN_COUNT];
    logic signed [WEIGHT_WIDTH-1:0] bias_w;
    logic [SCORE_W-1:0]             score_q [$];
    int                             mismatches;

    // Add one hidden-weight row into the hidden sums
    function automatic void add_row(ref longint sums [HIDDEN_COUNT], input int row);
        for (int n = 0; n < HIDDEN_COUNT; n++)
            sums[n] += longint'(hid_w[row * HIDDEN_COUNT + n]);
    endfunction

    // Score one evaluate word against the current weight store
    function automatic logic [SCORE_W-1:0] score_move(input logic [IN_DATA_W-1:0] d);
        longint sums [HIDDEN_COUNT];
        longint acc;
        logic signed [31:0] hist;
        logic signed [15:0] see;
        logic signed [16:0] margin;
        logic [7:0]         mnum;
        logic [2:0]         ptype;
        hist   = d[58:27];
        see    = d[74:59];
        margin = d[91:75];
        mnum   = d[99:92];
        ptype  = d[102:100];
        for (int n = 0; n < HIDDEN_COUNT; n++)
            sums[n] = 0;
        if (hist < -100)      add_row(sums, 0);
        else if (hist < 0)    add_row(sums, 1);
        else if (hist == 0)   add_row(sums, 2);
        else if (hist < 100)  add_row(sums, 3);
        else                  add_row(sums, 4);
        if (see >= 0)         add_row(sums, 5);
        if (margin >= 0)          add_row(sums, 6);
        else if (margin >= -100)  add_row(sums, 7);
        else if (margin >= -200)  add_row(sums, 8);
        else                      add_row(sums, 9);
        if (mnum < 5)         add_row(sums, 10);
        else if (mnum < 12)   add_row(sums, 11);
        else if (mnum < 29)   add_row(sums, 12);
        else                  add_row(sums, 13);
        if (ptype >= 1 && ptype <= 6)
            add_row(sums, 13 + int'(ptype));
        acc = longint'(bias_w) * 4096;
        for (int n = 0; n < HIDDEN_COUNT; n++)
            if (sums[n] > 0)
                acc += sums[n] * longint'(out_w[n]);
        // Saturate to the signed 32-bit range
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // Predict on input words, compare on result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_q.delete();
            fail_count = 0;
            mismatches = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    int addr;
                    addr = int'(s_tdata[10:0]);
                    if (addr < HIDDEN_WORDS)
                        hid_w[addr] = to_weight(s_tdata[26:11]);
                    else if (addr < BIAS_ADDR)
                        out_w[addr - HIDDEN_WORDS] = to_weight(s_tdata[26:11]);
                    else if (addr == BIAS_ADDR)
                        bias_w = to_weight(s_tdata[26:11]);
                end
                else
                    score_q.push_back(score_move(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (score_q.size() == 0)
                begin
                    fail_count++;
                    if (mismatches++ < 10)
                        $display("unexpected score word %h", m_tdata);
                end
                else
                begin
                    logic [SCORE_W-1:0] want;
                    want = score_q.pop_front();
                    if (want !== m_tdata)
                    begin
                        fail_count++;
                        if (mismatches++ < 10)
                            $display("score mismatch: expected %h actual %h", want, m_tdata);
                    end
                end
            end
        end
        pending_count = score_q.size();
    end

endmodule

// ===== tb/sparse_onehot_mlp_score_tb.sv =====
// Testbench top for the move scorer: loads weight sets, drives evaluate and load
// words with random gaps and stalls, and reports the verdict from the checker.
// Depends on smos_pkg, sparse_onehot_mlp_score and sparse_onehot_mlp_score_checker.
module sparse_onehot_mlp_score_tb import smos_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * HIDDEN_COUNT + 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SCORE_W-1:0]   m_tdata;
    int                   fail_count;
    int                   pending_count;
    int                   idle_cycles = 0;
    int                   src_run = 0;
    bit                   src_calm = 0;
    int                   weight_style = 0;

    sparse_onehot_mlp_score dut (.*);

    sparse_onehot_mlp_score_checker checker_i (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Draw a gap, with stretches of back-to-back words
    function automatic int draw_gap(ref int run, ref bit calm);
        if (run == 0)
        begin
            run  = $urandom_range(1, 40);
            calm = ($urandom_range(0, 2) == 0);
        end
        run--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Stall the result side at random
    initial
    begin
        int gap;
        int run;
        bit calm;
        run = 0;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(run, calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Send one word and hold it until accepted
    task automatic send_word(input bit load, input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = draw_gap(src_run, src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= load;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [15:0] weight_word();
        case (weight_style)
            0: return 16'($signed($urandom_range(0, 1023)) - 512);
            1: return 16'($urandom);
            default:
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'($urandom);
                endcase
        endcase
    endfunction

    task automatic load_weight(input int addr, input logic [15:0] v);
        logic [IN_DATA_W-1:0] d;
        d = {IN_DATA_W{1'b0}};
        d[10:0]  = 11'(addr);
        d[26:11] = v;
        d[107:27] = 81'({$urandom, $urandom, $urandom});
        send_word(1'b1, d);
    endtask

    task automatic evaluate(input logic [31:0] hist, input logic [15:0] see,
                            input logic [16:0] margin, input logic [7:0] mnum,
                            input logic [7:0] piece);
        logic [IN_DATA_W-1:0] d;
        d = {4'b0, piece, mnum, margin, see, hist, 16'($urandom), 11'($urandom)};
        send_word(1'b0, d);
    endtask

    function automatic logic [31:0] pick_hist();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2)) - 101);
            3: return 32'($signed($urandom_range(0, 2)) - 1);
            4: return 32'($urandom_range(98, 101));
            5: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] pick_margin();
        case ($urandom_range(0, 7))
            0: return 17'($signed($urandom_range(0, 2)) - 1);
            1: return 17'($signed($urandom_range(0, 2)) - 101);
            2: return 17'($signed($urandom_range(0, 2)) - 201);
            3: return 17'h10000;
            4: return 17'h0ffff;
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_mnum();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(3, 6));
            1: return 8'($urandom_range(10, 13));
            2: return 8'($urandom_range(27, 30));
            default: return 8'($urandom);
        endcase
    endfunction

    // Random mix of evaluate words and in-range loads, a few ignored loads
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_weight($urandom_range(BIAS_ADDR + 1, 2047), 16'($urandom));
                else
                    load_weight($urandom_range(0, BIAS_ADDR), weight_word());
            end
            else
                evaluate(pick_hist(), 16'($urandom), pick_margin(), pick_mnum(),
                         8'($urandom));
        end
    endtask

    task automatic load_all();
        for (int a = 0; a <= BIAS_ADDR; a++)
            load_weight(a, weight_word());
    endtask

    // Reload the output weights and the bias only
    task automatic load_outputs();
        for (int a = INPUT_COUNT * HIDDEN_COUNT; a <= BIAS_ADDR; a++)
            load_weight(a, weight_word());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small weights first, so scores stay inside the range
        weight_style = 0;
        load_all();

        // Bucket edges and extremes of each field
        evaluate(32'h8000_0000, 16'h8000, 17'h10000, 8'd0, 8'd0);
        evaluate(32'h7fff_ffff, 16'h7fff, 17'h0ffff, 8'd255, 8'd255);
        evaluate(-32'sd101, 16'h0000, 17'h00000, 8'd4, 8'd1);
        evaluate(-32'sd100, 16'hffff, -17'sd1, 8'd5, 8'd2);
        evaluate(-32'sd1, 16'h0001, -17'sd100, 8'd11, 8'd3);
        evaluate(32'd0, 16'h0000, -17'sd101, 8'd12, 8'd4);
        evaluate(32'd1, 16'h8000, -17'sd200, 8'd28, 8'd5);
        evaluate(32'd99, 16'h7fff, -17'sd201, 8'd29, 8'd6);
        evaluate(32'd100, 16'h0000, 17'd0, 8'd30, 8'd7);
        // Piece codes with the type in the low bits only
        evaluate(32'd0, 16'h0000, 17'd0, 8'd0, 8'hf8);
        evaluate(32'd0, 16'h0000, 17'd0, 8'd0, 8'hfe);
        // Ignored loads beyond the bias, then a bias change
        load_weight(BIAS_ADDR + 1, 16'h7fff);
        load_weight(2047, 16'h8000);
        evaluate(32'd5, 16'h0005, 17'd5, 8'd5, 8'd3);
        load_weight(BIAS_ADDR, 16'h7fff);
        evaluate(32'd5, 16'h0005, 17'd5, 8'd5, 8'd3);
        load_weight(BIAS_ADDR, 16'h8000);
        evaluate(32'd5, 16'h0005, 17'd5, 8'd5, 8'd3);

        random_phase(200);
        // Full-range output weights drive the score into saturation
        weight_style = 1;
        load_outputs();
        random_phase(80);
        weight_style = 2;
        load_outputs();
        random_phase(80);
        s_tvalid <= 1'b0;

        // Drain the pipeline
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/smos_pkg.sv
sv/smos_head.sv
sv/smos_cell.sv
sv/sparse_onehot_mlp_score.sv
tb/sparse_onehot_mlp_score_checker.sv
tb/sparse_onehot_mlp_score_tb.sv
